@@ rtl/prlf_pkg.sv @@
`timescale 1ns / 1ps

package prlf_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned QueueDepth = 4;
  localparam logic [15:0] MarginBase = 16'hff00;
  localparam logic [15:0] MarginMax = 16'hfeff;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_DATA  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_MARGIN = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EOL    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_VBLANK_LINES    = 3'd0,
    REG_IMAGE_LINES     = 3'd1,
    REG_LAST_WORD_INDEX = 3'd2,
    REG_LEFT_BITS       = 3'd3,
    REG_RIGHT_BITS      = 3'd4,
    REG_HBLANK_BASE     = 3'd5,
    REG_X_OFFSET        = 3'd6
  } reg_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [WordBits-1:0] pixel_word;
  } in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [WordBits-1:0] value;
    logic                page_done;
    logic                last;
  } out_t;

endpackage

@@ rtl/printer_raster_line_feeder.sv @@
`timescale 1ns / 1ps

// Raster line feeder: formats one page of 1-bit pixel words for the video FIFO.
// Input channel in_*: one beat carries a mode (start page, blank-line tick,
// data word) and a 32-bit pixel word. Output channel out_*: each beat is a
// margin value, a masked data word or an end-of-line zero word; last marks
// the final beat caused by one input beat, page_done the marker closing a page.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Throughput: one input beat per cycle while the queue has room; the word that
// ends a line makes two output beats, so a stream of lines is paced by the
// output side. The four-entry result queue and the input register set this rate.
// Stall: a stalled receiver fills the queue to under two free entries, then
// the input register holds and in_stall_o rises; no beat is lost or repeated.
// Reset clears the page state and the queue; registers return to their
// defaults (84 blank lines, 255 horizontal blank, all else zero).
// Configuration: cfg_we_i writes register cfg_idx_i; an index of seven is ignored.
module printer_raster_line_feeder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  prlf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output prlf_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);

  localparam int unsigned WB = prlf_pkg::WordBits;

  logic [15:0] vblank_q, image_q, hblank_q;
  logic [15:0] xoff_q;
  logic [7:0]  lwi_q;
  logic [4:0]  left_q, right_q;

  prlf_pkg::in_t in_q;
  logic          in_vld_q, in_vld_d;
  logic          active_q, active_d;
  logic [7:0]    word_pos_q, word_pos_d;
  logic [16:0]   line_q, line_d;

  logic           room;
  logic           proc;
  logic           accept;
  logic [1:0]     push_cnt;
  prlf_pkg::out_t res0, res1;

  logic [16:0]        total;
  logic [16:0]        line_inc;
  logic               done;
  logic               in_image;
  logic               end_line;
  logic [WB-1:0]      word;
  logic signed [19:0] span;
  logic signed [19:0] margin_raw;
  logic [15:0]        margin;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = in_vld_q && !room;
  assign proc       = in_vld_q && room;

  assign total    = {1'b0, vblank_q} + {1'b0, image_q};
  assign line_inc = line_q + 17'd1;
  assign done     = (line_inc >= total);
  assign in_image = (line_q >= {1'b0, vblank_q});
  assign end_line = (word_pos_q >= lwi_q);

  assign span = $signed({4'b0, hblank_q}) - $signed({15'b0, left_q})
              + $signed({{4{xoff_q[15]}}, xoff_q});
  assign margin_raw = $signed({4'b0, prlf_pkg::MarginBase}) - span;

  always_comb begin
    if (margin_raw < 0) begin
      margin = '0;
    end else if (margin_raw > $signed({4'b0, prlf_pkg::MarginMax})) begin
      margin = prlf_pkg::MarginMax;
    end else begin
      margin = margin_raw[15:0];
    end
  end

  always_comb begin
    word = in_q.pixel_word;
    if (word_pos_q == 8'd0 && left_q != 5'd0) begin
      word = word & ({WB{1'b1}} >> left_q);
    end
    if (end_line && right_q != 5'd0) begin
      word = word & ~({WB{1'b1}} >> right_q);
    end
  end

  always_comb begin
    active_d   = active_q;
    word_pos_d = word_pos_q;
    line_d     = line_q;
    push_cnt   = 2'd0;
    res0       = '{kind: prlf_pkg::KIND_EOL, value: '0, page_done: done, last: 1'b1};
    res1       = '{kind: prlf_pkg::KIND_EOL, value: '0, page_done: done, last: 1'b1};
    if (proc) begin
      case (in_q.mode)
        prlf_pkg::MODE_START: begin
          word_pos_d = '0;
          line_d     = '0;
          active_d   = (total != 17'd0);
          res0.kind  = prlf_pkg::KIND_MARGIN;
          res0.value = WB'(margin);
          res0.page_done = 1'b0;
          push_cnt   = 2'd1;
        end
        prlf_pkg::MODE_TICK: begin
          if (active_q && !in_image) begin
            line_d   = line_inc;
            active_d = !done;
            push_cnt = 2'd1;
          end
        end
        prlf_pkg::MODE_DATA: begin
          if (active_q && in_image) begin
            res0.kind      = prlf_pkg::KIND_DATA;
            res0.value     = word;
            res0.page_done = 1'b0;
            if (!end_line) begin
              word_pos_d = word_pos_q + 8'd1;
              push_cnt   = 2'd1;
            end else begin
              res0.last  = 1'b0;
              word_pos_d = '0;
              line_d     = line_inc;
              active_d   = !done;
              push_cnt   = 2'd2;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      active_q   <= 1'b0;
      word_pos_q <= '0;
      line_q     <= '0;
    end else begin
      in_vld_q   <= in_vld_d;
      active_q   <= active_d;
      word_pos_q <= word_pos_d;
      line_q     <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vblank_q <= 16'd84;
      image_q  <= '0;
      lwi_q    <= '0;
      left_q   <= '0;
      right_q  <= '0;
      hblank_q <= 16'd255;
      xoff_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        prlf_pkg::REG_VBLANK_LINES:    vblank_q <= cfg_wdata_i;
        prlf_pkg::REG_IMAGE_LINES:     image_q  <= cfg_wdata_i;
        prlf_pkg::REG_LAST_WORD_INDEX: lwi_q    <= cfg_wdata_i[7:0];
        prlf_pkg::REG_LEFT_BITS:       left_q   <= cfg_wdata_i[4:0];
        prlf_pkg::REG_RIGHT_BITS:      right_q  <= cfg_wdata_i[4:0];
        prlf_pkg::REG_HBLANK_BASE:     hblank_q <= cfg_wdata_i;
        prlf_pkg::REG_X_OFFSET:        xoff_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  prlf_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .first_i     (res0),
    .second_i    (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.mode == prlf_pkg::MODE_START |=> word_pos_q == '0 && line_q == '0)
    else $error("start beat did not clear the line counters");

  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt != 2'd0 && in_q.mode != prlf_pkg::MODE_START
      && (res0.kind == prlf_pkg::KIND_EOL || push_cnt == 2'd2) && done |=> !active_q)
    else $error("page stayed open after its final marker");

  a_out_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(proc))
    else $error("output beat appeared without a processed input beat");

endmodule

@@ rtl/prlf_out_queue.sv @@
`timescale 1ns / 1ps

module prlf_out_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  prlf_pkg::out_t  first_i,
  input  prlf_pkg::out_t  second_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output prlf_pkg::out_t  out_data_o
);

  localparam int unsigned PtrW = $clog2(prlf_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(prlf_pkg::QueueDepth + 1);

  prlf_pkg::out_t entry_q [prlf_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [PtrW-1:0] wr_next;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign room_o      = (cnt_q <= CntW'(prlf_pkg::QueueDepth - 2));
  assign wr_next     = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= first_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_next] <= second_i;
    end
  end

endmodule
